[rtl/kmm_pkg.sv]
`timescale 1ns / 1ps

package kmm_pkg;

   localparam int WAYS_DEFAULT = 16;
   localparam int WAYS_MAX     = 64;
   localparam int WAY_IDX_W    = $clog2(WAYS_MAX);
   localparam int WAY_W        = 4;
   localparam int VALUE_W      = 32;
   localparam int CFG_W        = 5;
   localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = CFG_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN
   } kmm_state_type;

   typedef struct packed {
      logic                       write;
      logic                       pick;
      logic                       clear;
      logic                       run_end;
      logic signed [VALUE_W-1:0]  value;
   } kmm_cell_ctl_type;

   typedef struct packed {
      logic waiting;
      logic exhausted;
   } kmm_cell_stat_type;

   typedef struct packed {
      logic                       found;
      logic signed [VALUE_W-1:0]  value;
      logic [WAY_IDX_W-1:0]       way;
   } kmm_best_type;

endpackage

[rtl/kmm_if.sv]
`timescale 1ns / 1ps

interface kmm_req_if;
   logic                                valid;
   logic                                ready;
   logic [kmm_pkg::WAY_W-1:0]           way;
   logic signed [kmm_pkg::VALUE_W-1:0]  value;
   logic                                run_end;

   modport source (output valid, output way, output value, output run_end, input ready);
   modport sink (input valid, input way, input value, input run_end, output ready);
endinterface

interface kmm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kmm_pkg::VALUE_W-1:0]  merged_value;
   logic [kmm_pkg::WAY_W-1:0]           source_way;
   logic                                done_res;

   modport source (output valid, output merged_value, output source_way, output done_res,
                   input ready);
   modport sink (input valid, input merged_value, input source_way, input done_res,
                 output ready);
endinterface

interface kmm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [kmm_pkg::CFG_W-1:0]   ways_in_use;

   modport source (output valid, output ways_in_use, input ready);
   modport sink (input valid, input ways_in_use, output ready);
endinterface

[rtl/kway_min_merge.sv]
`timescale 1ns / 1ps

// K-way merge of ascending runs into one ascending stream, one head per way held in a
// row of cells. An item is a refill value or an end-of-run mark for one way; items for
// an inactive way or a way that is not waiting are dropped. An item passes IDLE and CHECK
// when it yields no result or the done result, and also SCAN (ways_in_use clamped to
// 1..WAYS) when it completes the set of heads: the running minimum travels down the cell
// row one cell per cycle and is read at the last active cell. Results sit in an output
// register; a result that finds that register still full holds until it is taken. The
// user must write ways_in_use (reset 16) only while the block is idle (not enforced).
module kway_min_merge #(
   parameter int WAYS = kmm_pkg::WAYS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   kmm_req_if.sink       req_if,
   kmm_rsp_if.source     rsp_if,
   kmm_csr_if.sink       csr_if
);

   localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   kmm_pkg::kmm_state_type                state_ff, state_in;
   logic [IDX_W-1:0]                      cnt_ff, cnt_in;
   logic [kmm_pkg::CFG_W-1:0]             ways_ff;
   logic                                  rsp_valid_ff;
   logic signed [kmm_pkg::VALUE_W-1:0]    merged_value_ff;
   logic [kmm_pkg::WAY_W-1:0]             source_way_ff;
   logic                                  done_res_ff;

   logic                                  write_en;
   logic                                  load_done;
   logic                                  load_min;
   logic                                  clear;
   logic                                  slot_free;
   logic                                  all_done;
   logic                                  any_waiting;
   logic [IDX_W-1:0]                      tap_idx;
   logic [WAYS-1:0]                       active;
   logic [WAYS-1:0]                       live;
   logic [WAYS-1:0]                       pending;

   kmm_pkg::kmm_cell_ctl_type             cell_ctl [WAYS];
   kmm_pkg::kmm_cell_stat_type            cell_stat [WAYS];
   kmm_pkg::kmm_best_type                 cell_best [WAYS];
   kmm_pkg::kmm_best_type                 chain_head;
   kmm_pkg::kmm_best_type                 best_sel;

   assign chain_head.found = 1'b0;
   assign chain_head.value = '0;
   assign chain_head.way   = '0;

   for (genvar g = 0; g < WAYS; g++) begin : g_cell
      assign active[g] = (ways_ff == '0) ? (g == 0) : (32'(ways_ff) > g);
      assign live[g]    = active[g] && !cell_stat[g].exhausted;
      assign pending[g] = live[g] && cell_stat[g].waiting;

      assign cell_ctl[g].write   = write_en && active[g] && (32'(req_if.way) == g);
      assign cell_ctl[g].pick    = load_min && (best_sel.way == kmm_pkg::WAY_IDX_W'(g));
      assign cell_ctl[g].clear   = clear;
      assign cell_ctl[g].run_end = req_if.run_end;
      assign cell_ctl[g].value   = req_if.value;

      kmm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active[g]),
         .way_idx (kmm_pkg::WAY_IDX_W'(g)),
         .ctl     (cell_ctl[g]),
         .prev    ((g == 0) ? chain_head : cell_best[(g == 0) ? 0 : g - 1]),
         .best    (cell_best[g]),
         .stat    (cell_stat[g])
      );
   end

   assign all_done    = (live == '0);
   assign any_waiting = (pending != '0);
   assign slot_free   = !rsp_valid_ff || rsp_if.ready;
   assign best_sel    = cell_best[tap_idx];

   always_comb begin
      if (ways_ff == '0) begin
         tap_idx = '0;
      end else if (32'(ways_ff) > WAYS) begin
         tap_idx = IDX_W'(WAYS - 1);
      end else begin
         tap_idx = IDX_W'(ways_ff - kmm_pkg::CFG_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      write_en  = 1'b0;
      load_done = 1'b0;
      load_min  = 1'b0;
      clear     = 1'b0;
      unique case (state_ff)
         kmm_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               write_en = 1'b1;
               state_in = kmm_pkg::ST_CHECK;
            end
         end
         kmm_pkg::ST_CHECK: begin
            priority if (all_done) begin
               if (slot_free) begin
                  load_done = 1'b1;
                  clear     = 1'b1;
                  state_in  = kmm_pkg::ST_IDLE;
               end
            end else if (any_waiting) begin
               state_in = kmm_pkg::ST_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = kmm_pkg::ST_SCAN;
            end
         end
         kmm_pkg::ST_SCAN: begin
            if (cnt_ff == tap_idx) begin
               if (slot_free) begin
                  load_min = 1'b1;
                  state_in = kmm_pkg::ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = kmm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_if.ready = (state_ff == kmm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= kmm_pkg::WAYS_IN_USE_RESET;
      end else if (csr_if.valid) begin
         ways_ff <= csr_if.ways_in_use;
      end
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_done || load_min) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_done) begin
         merged_value_ff <= '0;
         source_way_ff   <= '0;
         done_res_ff     <= 1'b1;
      end else if (load_min) begin
         merged_value_ff <= best_sel.value;
         source_way_ff   <= kmm_pkg::WAY_W'(best_sel.way);
         done_res_ff     <= 1'b0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.merged_value = merged_value_ff;
   assign rsp_if.source_way   = source_way_ff;
   assign rsp_if.done_res     = done_res_ff;

endmodule

[rtl/kmm_cell.sv]
`timescale 1ns / 1ps

module kmm_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              active,
   input  logic [kmm_pkg::WAY_IDX_W-1:0]     way_idx,
   input  kmm_pkg::kmm_cell_ctl_type         ctl,
   input  kmm_pkg::kmm_best_type             prev,
   output kmm_pkg::kmm_best_type             best,
   output kmm_pkg::kmm_cell_stat_type        stat
);

   logic                                 waiting_ff;
   logic                                 exhausted_ff;
   logic signed [kmm_pkg::VALUE_W-1:0]   head_ff;
   kmm_pkg::kmm_best_type                best_ff;
   kmm_pkg::kmm_best_type                best_in;
   logic                                 refill;
   logic                                 take;

   assign refill = ctl.write && waiting_ff && !exhausted_ff;
   assign take   = active && !exhausted_ff && (!prev.found || (head_ff < prev.value));

   always_comb begin
      if (take) begin
         best_in.found = 1'b1;
         best_in.value = head_ff;
         best_in.way   = way_idx;
      end else begin
         best_in = prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         waiting_ff   <= 1'b1;
         exhausted_ff <= 1'b0;
      end else if (refill) begin
         waiting_ff <= 1'b0;
         if (ctl.run_end) begin
            exhausted_ff <= 1'b1;
         end
      end else if (ctl.pick) begin
         waiting_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (refill && !ctl.run_end) begin
         head_ff <= ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.found <= 1'b0;
      end else begin
         best_ff.found <= best_in.found;
      end
      best_ff.value <= best_in.value;
      best_ff.way   <= best_in.way;
   end

   assign best           = best_ff;
   assign stat.waiting   = waiting_ff;
   assign stat.exhausted = exhausted_ff;

endmodule

[rtl/kmm_checker.sv]
`timescale 1ns / 1ps

module kmm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [kmm_pkg::VALUE_W-1:0]  rsp_merged_value,
   input  logic [kmm_pkg::WAY_W-1:0]           rsp_source_way,
   input  logic                                rsp_done_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_merged_value)
         && $stable(rsp_source_way) && $stable(rsp_done_res))
      else $error("result changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> (rsp_merged_value == '0) && (rsp_source_way == '0))
      else $error("done result carries a nonzero payload");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

endmodule

bind kway_min_merge kmm_checker u_kmm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_merged_value (rsp_if.merged_value),
   .rsp_source_way   (rsp_if.source_way),
   .rsp_done_res     (rsp_if.done_res)
);
